// ===== sv/audio_dc_block_envelope_assert.svh =====
// Assertion macros for the DC-block envelope block.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef AUDIO_DC_BLOCK_ENVELOPE_ASSERT_SVH
`define AUDIO_DC_BLOCK_ENVELOPE_ASSERT_SVH

// same-cycle implication
`define ADBE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ADBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/adbe_pkg.sv =====
// Shared constants, types and saturation helper for the DC-block envelope block.
// No dependencies.
package adbe_pkg;

   localparam int unsigned SAMPLE_SHIFT_DEF = 14;

   localparam logic [15:0] GAIN_MIN   = 16'd410;
   localparam logic [15:0] GAIN_MAX   = 16'd40960;
   localparam logic [15:0] GAIN_RESET = 16'd4096;

   localparam logic [15:0] C_POLE    = 16'd32604;
   localparam logic [15:0] C_ATT_NEW = 16'd19661;
   localparam logic [15:0] C_DEC_NEW = 16'd2621;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic load;
      logic last;
   } stage_ctl_type;

   function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'(S32_MAX)) begin
         r = S32_MAX;
      end else if (v < 64'(S32_MIN)) begin
         r = S32_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/adbe_req_if.sv =====
// Input channel of the DC-block envelope block: slot word and buffer marker.
// No dependencies.
interface adbe_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] raw_slot;
   logic               last_in_buffer;

   modport source (output valid, output raw_slot, output last_in_buffer, input ready);
   modport sink   (input valid, input raw_slot, input last_in_buffer, output ready);
endinterface

// ===== sv/adbe_rsp_if.sv =====
// Result channel of the DC-block envelope block: filtered sample, peak, envelope.
// No dependencies.
interface adbe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] filtered_sample;
   logic               buffer_done;
   logic [31:0]        peak_to_peak;
   logic [31:0]        envelope;

   modport source (output valid, output filtered_sample, output buffer_done,
                   output peak_to_peak, output envelope, input ready);
   modport sink   (input valid, input filtered_sample, input buffer_done,
                   input peak_to_peak, input envelope, output ready);
endinterface

// ===== sv/adbe_scale.sv =====
// Input scaling stage: arithmetic shift of the slot word, gain multiply, round, saturate.
// Depends on adbe_pkg.
module adbe_scale
   import adbe_pkg::*;
#(
   parameter int unsigned SAMPLE_SHIFT = SAMPLE_SHIFT_DEF
) (
   input  logic               clock,
   input  stage_ctl_type      ctl,
   input  logic signed [31:0] raw_slot,
   input  logic [15:0]        gain,
   output logic signed [31:0] xs_ff,
   output logic               last_ff
);
   localparam int unsigned XW = 32 - SAMPLE_SHIFT;
   localparam int unsigned PW = XW + 17;

   logic signed [XW-1:0] x;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] rnd;
   logic signed [31:0]   xs_in;

   assign x     = $signed(raw_slot[31:SAMPLE_SHIFT]);
   assign prod  = PW'(x) * PW'($signed({1'b0, gain}));
   assign rnd   = (prod + $signed(PW'(8))) >>> 4;
   assign xs_in = sat_s32(64'(rnd));

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         xs_ff   <= xs_in;
         last_ff <= ctl.last;
      end
   end
endmodule

// ===== sv/adbe_dcblk.sv =====
// DC-blocking IIR stage: y = x - x1 + 0.995*y1 in Q15, saturated to 32 bits.
// Depends on adbe_pkg.
module adbe_dcblk
   import adbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  stage_ctl_type      ctl,
   input  logic signed [31:0] xs,
   output logic signed [31:0] ys_ff,
   output logic               last_ff
);
   logic signed [31:0] prev_in_ff;
   logic signed [31:0] prev_out_ff;
   logic signed [47:0] prod;
   logic signed [47:0] fb;
   logic signed [63:0] y;
   logic signed [31:0] ys_in;

   assign prod  = 48'(prev_out_ff) * 48'($signed({1'b0, C_POLE}));
   assign fb    = (prod + 48'sd16384) >>> 15;
   assign y     = 64'(xs) - 64'(prev_in_ff) + 64'(fb);
   assign ys_in = sat_s32(y);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_in_ff  <= '0;
         prev_out_ff <= '0;
      end else if (ctl.load) begin
         prev_in_ff  <= xs;
         prev_out_ff <= ys_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         ys_ff   <= ys_in;
         last_ff <= ctl.last;
      end
   end
endmodule

// ===== sv/adbe_range.sv =====
// Buffer range stage: running min/max over the buffer and peak-to-peak on its last item.
// Depends on adbe_pkg.
module adbe_range
   import adbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  stage_ctl_type      ctl,
   input  logic signed [31:0] ys,
   output logic signed [31:0] ys_ff,
   output logic               last_ff,
   output logic [31:0]        p2p_ff
);
   logic signed [31:0] max_ff;
   logic signed [31:0] min_ff;
   logic signed [31:0] hi;
   logic signed [31:0] lo;
   logic signed [32:0] d;

   assign hi = (ys > max_ff) ? ys : max_ff;
   assign lo = (ys < min_ff) ? ys : min_ff;
   assign d  = 33'(hi) - 33'(lo);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= S32_MIN;
         min_ff <= S32_MAX;
      end else if (ctl.load) begin
         if (ctl.last) begin
            max_ff <= S32_MIN;
            min_ff <= S32_MAX;
         end else begin
            max_ff <= hi;
            min_ff <= lo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         ys_ff   <= ys;
         last_ff <= ctl.last;
         p2p_ff  <= d[31:0];
      end
   end
endmodule

// ===== sv/adbe_env.sv =====
// Envelope stage and result register: attack/decay smoothing of the buffer peak.
// Depends on adbe_pkg.
module adbe_env
   import adbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  stage_ctl_type      ctl,
   input  logic signed [31:0] ys,
   input  logic [31:0]        p2p,
   output logic signed [31:0] sample_ff,
   output logic               done_ff,
   output logic [31:0]        peak_ff,
   output logic [31:0]        env_ff
);
   logic [15:0]        wb;
   logic signed [32:0] diff;
   logic signed [49:0] prod;
   logic signed [49:0] acc;

   assign wb   = (p2p > env_ff) ? C_ATT_NEW : C_DEC_NEW;
   assign diff = $signed({1'b0, p2p}) - $signed({1'b0, env_ff});
   assign prod = 50'(diff) * 50'($signed({1'b0, wb}));
   assign acc  = $signed({3'b000, env_ff, 15'b0}) + prod + 50'sd16384;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
         env_ff  <= '0;
      end else if (ctl.load && ctl.last) begin
         peak_ff <= p2p;
         env_ff  <= acc[46:15];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         sample_ff <= ys;
         done_ff   <= ctl.last;
      end
   end
endmodule

// ===== sv/audio_dc_block_envelope.sv =====
// DC-blocking filter with buffer envelope follower, top level.
// Depends on adbe_pkg, adbe_req_if, adbe_rsp_if and the adbe_* stage modules.
//
// One item in, one item out, one item per clock sustained while results are taken;
// each item passes through the input register, the scale, filter and range stages
// and the result register. Throughput is set by the feedback loops: the 0.995 pole
// multiply-add in the filter stage, the min/max update in the range stage and the
// attack/decay multiply-add in the envelope stage. The stages stall independently,
// so bubbles close up and the input stays open while a result waits until all stages
// are full. The input is not ready during reset. The gain register is clamped to
// 0.1..10 (Q4.12) on write and should only be written while no items are in flight.
`include "audio_dc_block_envelope_assert.svh"

module audio_dc_block_envelope
   import adbe_pkg::*;
#(
   parameter int unsigned SAMPLE_SHIFT = SAMPLE_SHIFT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   adbe_req_if.sink    req_bus,
   adbe_rsp_if.source  rsp_bus,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   logic [15:0]        gain_ff;
   logic [15:0]        gain_in;
   logic [4:0]         vld_ff;
   logic [4:0]         vld_in;
   logic [4:0]         ld;
   logic [4:0]         free;
   logic [4:0]         leave;
   logic signed [31:0] raw_ff;
   logic               last1_ff;
   logic signed [31:0] xs;
   logic               last2;
   logic signed [31:0] ys3;
   logic               last3;
   logic signed [31:0] ys4;
   logic               last4;
   logic [31:0]        p2p4;

   always_comb begin
      if (csr_wr_data < GAIN_MIN) begin
         gain_in = GAIN_MIN;
      end else if (csr_wr_data > GAIN_MAX) begin
         gain_in = GAIN_MAX;
      end else begin
         gain_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_wr_en) begin
         gain_ff <= gain_in;
      end
   end

   always_comb begin
      free[4] = !vld_ff[4] || rsp_bus.ready;
      ld      = '0;
      for (int k = 3; k >= 0; k--) begin
         ld[k+1] = vld_ff[k] && free[k+1];
         free[k] = !vld_ff[k] || ld[k+1];
      end
      ld[0] = req_bus.valid && free[0] && !reset;
   end

   assign leave  = {rsp_bus.ready, ld[4:1]};
   assign vld_in = ld | (vld_ff & ~leave);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // hold the accepted item
   always_ff @(posedge clock) begin
      if (ld[0]) begin
         raw_ff   <= req_bus.raw_slot;
         last1_ff <= req_bus.last_in_buffer;
      end
   end

   adbe_scale #(
      .SAMPLE_SHIFT(SAMPLE_SHIFT)
   ) u_scale (
      .clock    (clock),
      .ctl      ('{load: ld[1], last: last1_ff}),
      .raw_slot (raw_ff),
      .gain     (gain_ff),
      .xs_ff    (xs),
      .last_ff  (last2)
   );

   adbe_dcblk u_dcblk (
      .clock   (clock),
      .reset   (reset),
      .ctl     ('{load: ld[2], last: last2}),
      .xs      (xs),
      .ys_ff   (ys3),
      .last_ff (last3)
   );

   adbe_range u_range (
      .clock   (clock),
      .reset   (reset),
      .ctl     ('{load: ld[3], last: last3}),
      .ys      (ys3),
      .ys_ff   (ys4),
      .last_ff (last4),
      .p2p_ff  (p2p4)
   );

   adbe_env u_env (
      .clock     (clock),
      .reset     (reset),
      .ctl       ('{load: ld[4], last: last4}),
      .ys        (ys4),
      .p2p       (p2p4),
      .sample_ff (rsp_bus.filtered_sample),
      .done_ff   (rsp_bus.buffer_done),
      .peak_ff   (rsp_bus.peak_to_peak),
      .env_ff    (rsp_bus.envelope)
   );

   assign req_bus.ready = free[0] && !reset;
   assign rsp_bus.valid = vld_ff[4];

   `ADBE_ASSERT_IMPLY(a_gain_range, clock, reset, 1'b1,
      (gain_ff >= GAIN_MIN) && (gain_ff <= GAIN_MAX), "gain register outside clamp range")
   `ADBE_ASSERT_NEXT(a_env_hold, clock, reset, !(ld[4] && last4),
      $stable(rsp_bus.envelope) && $stable(rsp_bus.peak_to_peak),
      "envelope changed without a buffer end")
   `ADBE_ASSERT_IMPLY(a_full_stall, clock, reset, (&vld_ff) && !rsp_bus.ready,
      !req_bus.ready, "item taken into a full stalled pipeline")
endmodule

// ===== tb/audio_dc_block_envelope_tb.sv =====
// Self-checking testbench for audio_dc_block_envelope: DC-block filter and envelope.
// Depends on adbe_pkg, the adbe_req_if and adbe_rsp_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module audio_dc_block_envelope_tb
   import adbe_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 225;
   localparam int HOLD_CYCLES    = 150;
   localparam int SETTLE_CYCLES  = 8;

   localparam logic signed [63:0] POLE_Q15    = 64'sd32604;
   localparam logic [63:0]        ATTACK_OLD  = 64'd13107;
   localparam logic [63:0]        ATTACK_NEW  = 64'd19661;
   localparam logic [63:0]        DECAY_OLD   = 64'd30147;
   localparam logic [63:0]        DECAY_NEW   = 64'd2621;
   localparam logic [15:0]        GAIN_FLOOR  = 16'd410;
   localparam logic [15:0]        GAIN_CEIL   = 16'd40960;
   localparam logic [15:0]        GAIN_UNITY  = 16'd4096;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               done;
      logic [31:0]        peak;
      logic [31:0]        env;
   } dcb_result_type;

   class envelope_scoreboard;
      logic [15:0]        gain;
      logic signed [31:0] prev_in;
      logic signed [31:0] prev_out;
      logic signed [31:0] buf_max;
      logic signed [31:0] buf_min;
      logic [31:0]        env_level;
      logic [31:0]        held_peak;
      dcb_result_type     due_results[$];
      int                 errors;
      int                 matched;

      function new();
         gain      = GAIN_UNITY;
         prev_in   = '0;
         prev_out  = '0;
         buf_max   = 32'sh8000_0000;
         buf_min   = 32'sh7FFF_FFFF;
         env_level = '0;
         held_peak = '0;
         errors    = 0;
         matched   = 0;
      endfunction

      function logic signed [31:0] clip32(logic signed [63:0] v);
         if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
         if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      function void set_gain(logic [15:0] value);
         if (value < GAIN_FLOOR) gain = GAIN_FLOOR;
         else if (value > GAIN_CEIL) gain = GAIN_CEIL;
         else gain = value;
      endfunction

      function void filter_and_track(logic signed [31:0] raw, logic last);
         logic signed [63:0] x;
         logic signed [63:0] g64;
         logic signed [63:0] fb;
         logic signed [63:0] y;
         logic signed [63:0] spread;
         logic signed [31:0] xs;
         logic signed [31:0] ys;
         logic [63:0]        acc;
         logic [31:0]        p2p;
         dcb_result_type     r;
         x   = 64'(raw);
         x   = x >>> SAMPLE_SHIFT_DEF;
         g64 = {48'd0, gain};
         xs  = clip32((x * g64 + 64'sd8) >>> 4);
         y   = 64'(prev_out);
         fb  = (y * POLE_Q15 + 64'sd16384) >>> 15;
         x   = 64'(xs);
         y   = 64'(prev_in);
         ys  = clip32(x - y + fb);
         prev_in  = xs;
         prev_out = ys;
         if (ys > buf_max) buf_max = ys;
         if (ys < buf_min) buf_min = ys;
         if (last) begin
            x      = 64'(buf_max);
            y      = 64'(buf_min);
            spread = x - y;
            if (spread < 0) p2p = '0;
            else if (spread > 64'sh0000_0000_FFFF_FFFF) p2p = 32'hFFFF_FFFF;
            else p2p = spread[31:0];
            held_peak = p2p;
            if (p2p > env_level) begin
               acc = {32'd0, env_level} * ATTACK_OLD + {32'd0, p2p} * ATTACK_NEW;
            end else begin
               acc = {32'd0, env_level} * DECAY_OLD + {32'd0, p2p} * DECAY_NEW;
            end
            acc = (acc + 64'd16384) >> 15;
            env_level = (acc > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            buf_max = 32'sh8000_0000;
            buf_min = 32'sh7FFF_FFFF;
         end
         r.sample = ys;
         r.done   = last;
         r.peak   = held_peak;
         r.env    = env_level;
         due_results.push_back(r);
      endfunction

      function void match_result(dcb_result_type got);
         dcb_result_type want;
         if (due_results.size() == 0) begin
            $error("unexpected result item: filtered_sample %0d", got.sample);
            errors++;
            return;
         end
         want = due_results.pop_front();
         matched++;
         if (got.sample !== want.sample) begin
            $error("filtered_sample: expected %0d, actual %0d", want.sample, got.sample);
            errors++;
         end
         if (got.done !== want.done) begin
            $error("buffer_done: expected %0d, actual %0d", want.done, got.done);
            errors++;
         end
         if (got.peak !== want.peak) begin
            $error("peak_to_peak: expected %0d, actual %0d", want.peak, got.peak);
            errors++;
         end
         if (got.env !== want.env) begin
            $error("envelope: expected %0d, actual %0d", want.env, got.env);
            errors++;
         end
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   adbe_req_if req_if ();
   adbe_rsp_if rsp_if ();

   audio_dc_block_envelope u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   envelope_scoreboard tracker = new();

   bit          idle_send = 1'b1;
   bit          idle_recv = 1'b1;
   int unsigned hold_asked = 0;
   int          items_sent = 0;
   int          buffers_sent = 0;
   int          gain_writes = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      int unsigned    hold_left;
      dcb_result_type got;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.sample = rsp_if.filtered_sample;
            got.done   = rsp_if.buffer_done;
            got.peak   = rsp_if.peak_to_peak;
            got.env    = rsp_if.envelope;
            tracker.match_result(got);
         end
         if (hold_asked != 0) begin
            hold_left  = hold_asked;
            hold_asked = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !(idle_recv && $urandom_range(99) < 24);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("audio_dc_block_envelope test failed");
            $finish;
         end
      end
   end

   task automatic offer_slot(input logic signed [31:0] raw, input logic last);
      while (idle_send && $urandom_range(99) < 24) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.raw_slot       <= raw;
      req_if.last_in_buffer <= last;
      do @(posedge clock); while (!req_if.ready);
      tracker.filter_and_track(raw, last);
      items_sent++;
      if (last) buffers_sent++;
   endtask

   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gain(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      tracker.set_gain(value);
      gain_writes++;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [31:0] pick_slot();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         case ($urandom_range(3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
         endcase
      end
      if (roll < 20) return $signed(32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000);
      if (roll < 30) return $signed({8'($urandom_range(0, 255)), 24'h000000} | 32'h0010_0000);
      return $signed($urandom);
   endfunction

   task automatic send_buffer(input int len);
      for (int i = 0; i < len; i++) offer_slot(pick_slot(), i == len - 1);
   endtask

   task automatic send_extremes();
      offer_slot(32'sh7FFF_FFFF, 1'b0);
      offer_slot(32'sh8000_0000, 1'b0);
      offer_slot(32'sh7FFF_FFFF, 1'b1);
      offer_slot(32'sh0000_0000, 1'b1);
   endtask

   initial begin
      logic [15:0] gain_plan[7];
      int          phase_start;
      int          len;
      gain_plan[0] = 16'd0;
      gain_plan[1] = 16'hFFFF;
      gain_plan[2] = GAIN_FLOOR;
      gain_plan[3] = GAIN_CEIL;
      gain_plan[4] = 16'($urandom_range(GAIN_FLOOR, GAIN_CEIL));
      gain_plan[5] = 16'd409;
      gain_plan[6] = GAIN_UNITY;

      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= '0;
      req_if.valid          <= 1'b0;
      req_if.raw_slot       <= '0;
      req_if.last_in_buffer <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_extremes();
      offer_slot(-32'sd1, 1'b0);
      offer_slot(32'sh0000_4000, 1'b0);
      offer_slot(-32'sh0000_4000, 1'b1);
      offer_slot(32'sh0000_3FFF, 1'b0);
      offer_slot(32'sh8000_0000, 1'b0);
      offer_slot(32'sh8000_0000, 1'b1);
      for (int i = 0; i < 8; i++) begin
         offer_slot(i[0] ? 32'sh8000_0000 : 32'sh7FFF_FF00, i == 7);
      end
      offer_slot(32'sh0000_4000, 1'b1);
      offer_slot(32'sh0000_0000, 1'b1);
      wait_results_drained();

      for (int p = 0; p < 7; p++) begin
         write_gain(gain_plan[p]);
         idle_send = (p != 2 && p != 3);
         idle_recv = (p != 2);
         if (p == 3) hold_asked = HOLD_CYCLES;
         phase_start = items_sent;
         send_extremes();
         while (items_sent - phase_start < PHASE_ITEMS) begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40);
            send_buffer(len);
            if (p == 4 && items_sent - phase_start >= PHASE_ITEMS / 2 &&
                items_sent - phase_start < PHASE_ITEMS / 2 + 41) begin
               wait_results_drained();
            end
         end
         wait_results_drained();
      end
      idle_send = 1'b1;
      idle_recv = 1'b1;

      $display("covered %0d items in %0d buffers across %0d gain writes,",
               items_sent, buffers_sent, gain_writes);
      $display("including clamped gains, a stalled output and a drain mid-stream");
      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("audio_dc_block_envelope test passed");
      end else begin
         $display("audio_dc_block_envelope test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/adbe_pkg.sv
sv/adbe_req_if.sv
sv/adbe_rsp_if.sv
sv/adbe_scale.sv
sv/adbe_dcblk.sv
sv/adbe_range.sv
sv/adbe_env.sv
sv/audio_dc_block_envelope.sv
tb/audio_dc_block_envelope_tb.sv
